>>> design/srg_pkg.sv
// ---------------------------------------------------------------------------
// srg_pkg: shared types and constants of the subtractive random generator
// Lag-table geometry, seeding constants and the sequencer state encoding.
// ---------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned WordW   = 31;
  localparam int unsigned TblLen  = 55;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned BoundW  = 32;

  localparam logic [IdxW-1:0] LastIdx    = IdxW'(TblLen - 1);
  localparam logic [IdxW-1:0] LagShort   = IdxW'(24);
  localparam logic [IdxW-1:0] LagOffset  = IdxW'(31);
  localparam logic [IdxW-1:0] SeedStep   = IdxW'(21);
  localparam logic [2:0]      RefreshCnt = 3'd7;

  localparam logic [WordW-1:0]  SeedReset = 31'd2147169489;
  localparam logic [BoundW-1:0] Two31     = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_RESEED  = 2'd0,
    MODE_RAW     = 2'd1,
    MODE_BOUNDED = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b0000_0000_0001,
    ST_SEED_TOP   = 12'b0000_0000_0010,
    ST_SEED_WR    = 12'b0000_0000_0100,
    ST_SEED_SUB   = 12'b0000_0000_1000,
    ST_REF_RD     = 12'b0000_0001_0000,
    ST_REF_WR     = 12'b0000_0010_0000,
    ST_DRAW_START = 12'b0000_0100_0000,
    ST_DRAW_RD    = 12'b0000_1000_0000,
    ST_DRAW_CHK   = 12'b0001_0000_0000,
    ST_DIV_LIM    = 12'b0010_0000_0000,
    ST_DIV_VAL    = 12'b0100_0000_0000,
    ST_DONE       = 12'b1000_0000_0000
  } state_e;

  // Request to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [BoundW-1:0] dividend;
    logic [BoundW-1:0] divisor;
  } div_req_t;

  // Status from the remainder unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BoundW-1:0] rem;
  } div_rsp_t;

  // Rotate a 31-bit seed right by one bit.
  function automatic logic [WordW-1:0] seed_rotate(input logic [WordW-1:0] s);
    return {s[0], s[WordW-1:1]};
  endfunction

endpackage

>>> design/srg_ram.sv
// ---------------------------------------------------------------------------
// srg_ram: generic RAM
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module srg_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 55
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> design/srg_rem.sv
// ---------------------------------------------------------------------------
// srg_rem: iterative unsigned remainder
// Restoring remainder of two 32-bit values, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module srg_rem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srg_pkg::div_req_t req_i,
  output srg_pkg::div_rsp_t rsp_o
);
  import srg_pkg::*;

  localparam int unsigned CntW = $clog2(BoundW);

  logic [BoundW-1:0] dvd_q, dvd_d;
  logic [BoundW-1:0] dvs_q, dvs_d;
  logic [BoundW-1:0] rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [BoundW:0]   shifted;
  logic [BoundW:0]   diff;

  assign shifted = {rem_q, dvd_q[BoundW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[BoundW-2:0], 1'b0};
      // The remainder stays below the divisor, so it fits in 32 bits.
      if (!diff[BoundW]) begin
        rem_d = diff[BoundW-1:0];
      end else begin
        rem_d = shifted[BoundW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(BoundW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q)
    else $error("remainder unit reports done while still busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("remainder done without a preceding busy cycle");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("remainder not below divisor");

endmodule

>>> design/subtractive_random_generator.sv
// ---------------------------------------------------------------------------
// subtractive_random_generator: lagged-Fibonacci generator, lags 55 and 24
// Sequencer around a 55-word lag table, one shared 31-bit subtractor and an
// iterative remainder unit for bounded draws.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_ready_o   mode_i, modulus_i
//  out      output     out_valid_o/out_ready_i value_o
//  cfg      input      cfg_we_i (no wait)      cfg_wdata_i (seed)
//
// A raw draw reads one table word, after a refresh pass once the words run
// out; a refresh pass rewrites each word via the RAM's single write port. A
// reseed writes the table and then runs seven refresh passes. A bounded draw
// adds a bit-serial remainder for the limit and one for the final value, plus
// one raw draw per rejected word. Reset needs no clearing pass: a table-valid
// flag makes an unwritten table read as zeros. One beat is in work at a time;
// a finished result waits in the output register.
// ---------------------------------------------------------------------------
module subtractive_random_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srg_pkg::WordW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [srg_pkg::BoundW-1:0] modulus_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [srg_pkg::WordW-1:0]  value_o
);
  import srg_pkg::*;

  state_e state_q, state_d;

  logic [WordW-1:0]  seed_q;
  logic [WordW-1:0]  s_q, s_d, prev_q, prev_d, nxt_q, nxt_d, t_q, t_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW:0]     pos_sum;
  logic [IdxW-1:0]   k_q, k_d;
  logic [2:0]        pass_q, pass_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   draw_addr_q, draw_addr_d;
  logic              tbl_valid_q, tbl_valid_d;
  logic              after_seed_q, after_seed_d;
  logic              bounded_q, bounded_d;
  logic [BoundW-1:0] m_q, m_d;
  logic [BoundW-1:0] limit_q, limit_d;
  logic [WordW-1:0]  result_q, result_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  value_q, value_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [WordW-1:0]  ram_wdata, ram_rdata_a, ram_rdata_b;
  logic [WordW-1:0]  rd_a, rd_b;

  logic [WordW-1:0]  sub_a, sub_b, sub_y;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              in_beat;

  srg_ram #(
    .Width (WordW),
    .Depth (TblLen)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  srg_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Until the table has been fully written once it reads as all zeros.
  assign rd_a = tbl_valid_q ? ram_rdata_a : '0;
  assign rd_b = tbl_valid_q ? ram_rdata_b : '0;

  // The one shared subtractor; the 31-bit wrap is the modulus.
  always_comb begin
    unique case (state_q)
      ST_SEED_WR: begin
        sub_a = prev_q;
        sub_b = nxt_q;
      end
      ST_SEED_SUB: begin
        sub_a = t_q;
        sub_b = s_q;
      end
      ST_REF_WR: begin
        sub_a = rd_a;
        sub_b = rd_b;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end
  assign sub_y = sub_a - sub_b;

  // Table port control.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = k_q;
    ram_wdata   = sub_y;
    ram_raddr_a = k_q;
    ram_raddr_b = (k_q < LagShort) ? (k_q + LagOffset) : (k_q - LagShort);
    unique case (state_q)
      ST_SEED_TOP: begin
        ram_we    = 1'b1;
        ram_waddr = LastIdx;
        ram_wdata = s_q;
      end
      ST_SEED_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q - 1'b1;
        ram_wdata = nxt_q;
      end
      ST_REF_WR: begin
        ram_we = 1'b1;
      end
      ST_DRAW_RD: begin
        ram_raddr_a = draw_addr_q;
      end
      default: begin
      end
    endcase
  end

  assign pos_sum    = {1'b0, pos_q} + {1'b0, SeedStep};
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    prev_d       = prev_q;
    nxt_d        = nxt_q;
    t_d          = t_q;
    pos_d        = pos_q;
    k_d          = k_q;
    pass_d       = pass_q;
    idx_d        = idx_q;
    draw_addr_d  = draw_addr_q;
    tbl_valid_d  = tbl_valid_q;
    after_seed_d = after_seed_q;
    bounded_d    = bounded_q;
    m_d          = m_q;
    limit_d      = limit_q;
    result_d     = result_q;
    out_valid_d  = out_valid_q;
    value_d      = value_q;

    div_req.start    = 1'b0;
    div_req.dividend = Two31;
    div_req.divisor  = m_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          result_d = '0;
          unique case (mode_e'(mode_i))
            MODE_RESEED: begin
              s_d          = seed_q;
              prev_d       = seed_q;
              nxt_d        = WordW'(1);
              pos_d        = SeedStep;
              tbl_valid_d  = 1'b1;
              after_seed_d = 1'b1;
              state_d      = ST_SEED_TOP;
            end
            MODE_RAW: begin
              bounded_d    = 1'b0;
              after_seed_d = 1'b0;
              state_d      = ST_DRAW_START;
            end
            MODE_BOUNDED: begin
              bounded_d    = 1'b1;
              after_seed_d = 1'b0;
              // Zero or anything above 2^31 counts as 2^31.
              if (modulus_i == '0 || modulus_i > Two31) begin
                m_d = Two31;
              end else begin
                m_d = modulus_i;
              end
              div_req.start    = 1'b1;
              div_req.dividend = Two31;
              div_req.divisor  = m_d;
              state_d          = ST_DIV_LIM;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SEED_TOP: begin
        state_d = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        t_d    = sub_y;
        prev_d = nxt_q;
        s_d    = seed_rotate(s_q);
        pos_d  = (pos_sum >= (IdxW+1)'(TblLen)) ? IdxW'(pos_sum - (IdxW+1)'(TblLen))
                                                 : pos_sum[IdxW-1:0];
        state_d = ST_SEED_SUB;
      end
      ST_SEED_SUB: begin
        nxt_d = sub_y;
        if (pos_q == '0) begin
          k_d     = '0;
          pass_d  = RefreshCnt;
          state_d = ST_REF_RD;
        end else begin
          state_d = ST_SEED_WR;
        end
      end
      ST_REF_RD: begin
        state_d = ST_REF_WR;
      end
      ST_REF_WR: begin
        if (k_q == LastIdx) begin
          k_d = '0;
          if (pass_q == 3'd1) begin
            tbl_valid_d = 1'b1;
            idx_d       = LastIdx;
            pass_d      = '0;
            if (after_seed_q) begin
              state_d = ST_DONE;
            end else begin
              draw_addr_d = LastIdx;
              state_d     = ST_DRAW_RD;
            end
          end else begin
            pass_d  = pass_q - 1'b1;
            state_d = ST_REF_RD;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_REF_RD;
        end
      end
      ST_DRAW_START: begin
        if (idx_q == '0 || idx_q > LastIdx) begin
          k_d     = '0;
          pass_d  = 3'd1;
          state_d = ST_REF_RD;
        end else begin
          draw_addr_d = idx_q - 1'b1;
          idx_d       = idx_q - 1'b1;
          state_d     = ST_DRAW_RD;
        end
      end
      ST_DRAW_RD: begin
        state_d = ST_DRAW_CHK;
      end
      ST_DRAW_CHK: begin
        if (!bounded_q) begin
          result_d = rd_a;
          state_d  = ST_DONE;
        end else if ({1'b0, rd_a} >= limit_q) begin
          state_d = ST_DRAW_START;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {1'b0, rd_a};
          state_d          = ST_DIV_VAL;
        end
      end
      ST_DIV_LIM: begin
        if (div_rsp.done) begin
          limit_d = Two31 - div_rsp.rem;
          state_d = ST_DRAW_START;
        end
      end
      ST_DIV_VAL: begin
        if (div_rsp.done) begin
          result_d = div_rsp.rem[WordW-1:0];
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = result_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_q       <= SeedReset;
      idx_q        <= '0;
      tbl_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      pass_q       <= '0;
      k_q          <= '0;
      pos_q        <= '0;
      after_seed_q <= 1'b0;
      bounded_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      idx_q        <= idx_d;
      tbl_valid_q  <= tbl_valid_d;
      out_valid_q  <= out_valid_d;
      pass_q       <= pass_d;
      k_q          <= k_d;
      pos_q        <= pos_d;
      after_seed_q <= after_seed_d;
      bounded_q    <= bounded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    prev_q      <= prev_d;
    nxt_q       <= nxt_d;
    t_q         <= t_d;
    draw_addr_q <= draw_addr_d;
    m_q         <= m_d;
    limit_q     <= limit_d;
    result_q    <= result_d;
    value_q     <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("draw index left the table");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SEED_TOP || state_q == ST_SEED_WR ||
                state_q == ST_REF_WR))
    else $error("table written outside seeding or refresh");

  a_pass_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REF_RD || state_q == ST_REF_WR) |-> (pass_q != '0))
    else $error("refresh running with no pass left");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("remainder unit started while busy");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside the done state");

endmodule
